@@ rtl/hsv_adj_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsv_adj_pkg
// shared types and constants for the hsv offset colour adjust block
// ---------------------------------------------------------------------------
package hsv_adj_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    CFG_HUE   = 2'd0,
    CFG_SAT   = 2'd1,
    CFG_VAL   = 2'd2,
    CFG_ALPHA = 2'd3
  } cfg_idx_e;

  // word handed from front to back: max, delta, chosen hue numerator and alpha
  typedef struct packed {
    logic [7:0]  mx;
    logic [7:0]  delta;
    logic [10:0] hnum;
    logic [7:0]  alpha;
  } front_word_t;

endpackage

@@ rtl/hsv_adj_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsv_adj_front
// classifies an rgba pixel: max, delta and the sector-biased hue numerator
// ---------------------------------------------------------------------------
module hsv_adj_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [7:0]                red_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                blue_i,
  input  logic [7:0]                alpha_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output hsv_adj_pkg::front_word_t  word_o
);

  logic [7:0] mx, mn, dl;
  logic signed [11:0] n;
  hsv_adj_pkg::front_word_t word_d, word_q;
  logic valid_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dl = mx - mn;
    if (mx == red_i) begin
      n = $signed({4'd0, green_i}) - $signed({4'd0, blue_i});
    end else if (mx == green_i) begin
      n = $signed({4'd0, blue_i}) - $signed({4'd0, red_i}) + $signed({3'd0, dl, 1'b0});
    end else begin
      n = $signed({4'd0, red_i}) - $signed({4'd0, green_i}) + $signed({2'd0, dl, 2'b0});
    end
    if (n < 0) n = n + $signed({2'd0, dl, 2'b0}) + $signed({3'd0, dl, 1'b0});
    word_d.mx    = mx;
    word_d.delta = dl;
    word_d.hnum  = n[10:0];
    word_d.alpha = alpha_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ rtl/hsv_adj_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsv_adj_queue
// short fifo between the front and back parts
// ---------------------------------------------------------------------------
module hsv_adj_queue #(
  parameter int unsigned Depth = hsv_adj_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  hsv_adj_pkg::front_word_t  word_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output hsv_adj_pkg::front_word_t  word_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  hsv_adj_pkg::front_word_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0] cnt_q, cnt_d;
  logic push, pop;

  assign ready_o = cnt_q != PtrW'(0) + (PtrW+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign push = valid_i && ready_o;
  assign pop  = valid_o && ready_i;
  assign word_o = mem_q[rd_q];

  always_comb begin
    wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_d;
      if (pop) rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= word_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count step");
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == (cnt_q != 0)) else $error("queue valid flag");
`endif

endmodule

@@ rtl/hsv_adj_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsv_adj_back
// pipelined hsv arithmetic: divide, offset, six-sector rebuild, byte rounding
// ---------------------------------------------------------------------------
module hsv_adj_back #(
  parameter int unsigned FracBits = hsv_adj_pkg::FracBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  hsv_adj_pkg::front_word_t  word_i,
  input  logic [15:0]               hue_shift_i,
  input  logic signed [17:0]        sat_shift_i,
  input  logic signed [17:0]        val_shift_i,
  input  logic signed [17:0]        alpha_shift_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [31:0]               data_o
);

  localparam int unsigned F = FracBits;
  localparam int unsigned DS = F + 2;  // divider steps, one quotient bit per stage
  localparam int unsigned NS = DS + 7;  // pipeline stages
  localparam logic [F:0] One = (F+1)'(1) << F;
  // 2^F = 255 * RecipQ + RecipR, so x * 2^F / 255 splits into a product and a small rest
  localparam logic [F:0] RecipQ = (F+1)'((64'd1 << F) / 64'd255);
  localparam logic [7:0] RecipR = 8'((64'd1 << F) % 64'd255);

  // one restoring step: {quotient bit, remainder}
  function automatic logic [11:0] div_step(input logic [11:0] rem2, input logic [10:0] den);
    logic [11:0] df;
    df = rem2 - {1'b0, den};
    if (rem2 >= {1'b0, den}) return {1'b1, df[10:0]};
    return {1'b0, rem2[10:0]};
  endfunction

  // round(x * 2^F / 255); the rest term is divided by adding its high byte back
  function automatic logic [F:0] by255(input logic [7:0] x);
    logic [15:0] z;
    logic [15:0] zq;
    z  = {8'd0, x} * {8'd0, RecipR} + 16'd127;
    zq = (z + {8'd0, z[15:8]} + 16'd1) >> 8;
    return (F+1)'(x) * RecipQ + (F+1)'(zq[7:0]);
  endfunction

  // signed offset to F bits, truncating toward zero when narrowing
  function automatic logic signed [F+3:0] scl(input logic signed [17:0] v);
    logic signed [F+19:0] w;
    w = (F+20)'(v);
    if (F >= 16) return (F+4)'(w <<< (F - 16));
    if (v < 0) return (F+4)'(-((-w) >>> (16 - F)));
    return (F+4)'(w >>> (16 - F));
  endfunction

  function automatic logic [F:0] clamp(input logic signed [F+3:0] x);
    if (x < 0) return '0;
    if (x > $signed({3'b0, One})) return One;
    return x[F:0];
  endfunction

  function automatic logic [7:0] to_byte(input logic [F:0] x);
    logic [F+8:0] m;
    m = ((F+9)'(x) << 8) - (F+9)'(x) + ((F+9)'(1) << (F - 1));
    return m[F+7:F];
  endfunction

  // stage registers
  logic [NS-1:0] v_q;
  logic adv;
  assign adv = !v_q[NS-1] || ready_i;
  assign ready_o = adv;

  // divider stages: saturation delta/max and hue numerator/(6*delta)
  logic [10:0]   dr_s [DS];
  logic [10:0]   dr_h [DS];
  logic [F+1:0]  dq_s [DS];
  logic [F+1:0]  dq_h [DS];
  logic [7:0]    dd_s [DS];
  logic [10:0]   dd_h [DS];
  logic [F:0]    dv [DS];
  logic [F:0]    da [DS];
  logic [DS-1:0] dnz;
  logic [11:0]   st_s [DS];
  logic [11:0]   st_h [DS];
  logic [10:0]   hden;
  logic [F+1:0]  qs_inc, qh_inc;
  // rounded quotients and scaled value and alpha
  logic [F:0] s1_val, s1_sat, s1_alp;
  logic [F-1:0] s1_hue;
  // stage 2: offsets
  logic [F-1:0] s2_hue;
  logic [F:0] s2_sat, s2_val, s2_alp;
  // stage 3: sector and fraction, s*f products
  logic [2:0] s3_sec;
  logic [F:0] s3_sat, s3_val, s3_alp;
  logic [F-1:0] s3_f;
  // stage 4: s*f and s*(1-f) rounded
  logic [2:0] s4_sec;
  logic [F:0] s4_sat, s4_val, s4_alp, s4_sf, s4_sg;
  // stage 5: p q t
  logic [2:0] s5_sec;
  logic [F:0] s5_val, s5_alp, s5_p, s5_q, s5_t;
  // stage 6: channel pick
  logic [F:0] s6_r, s6_g, s6_b, s6_a;
  // stage 7/8: bytes
  logic [31:0] s7_d, s8_d;

  logic [F+2:0] h6;
  logic [2*F+1:0] pr_f, pr_g, pr_p, pr_q, pr_t;
  logic [F-1:0] hsh;

  always_comb begin
    if (F >= 16) hsh = F'({16'b0, hue_shift_i} << (F - 16));
    else hsh = F'(hue_shift_i >> (16 - F));
  end

  assign hden = {1'b0, word_i.delta, 2'b0} + {2'b0, word_i.delta, 1'b0};

  always_comb begin
    st_s[0] = div_step({4'd0, word_i.delta}, {3'd0, word_i.mx});
    st_h[0] = div_step({1'b0, word_i.hnum}, hden);
    for (int k = 1; k < DS; k++) begin
      st_s[k] = div_step({dr_s[k-1], 1'b0}, {3'd0, dd_s[k-1]});
      st_h[k] = div_step({dr_h[k-1], 1'b0}, dd_h[k-1]);
    end
  end

  // quotient carries one extra bit, so rounding half up is (q + 1) >> 1
  assign qs_inc = dq_s[DS-1] + (F+2)'(1);
  assign qh_inc = dq_h[DS-1] + (F+2)'(1);
  assign s1_sat = dnz[DS-1] ? qs_inc[F+1:1] : '0;
  assign s1_hue = dnz[DS-1] ? qh_inc[F:1] : '0;
  assign s1_val = dv[DS-1];
  assign s1_alp = da[DS-1];

  assign h6   = (F+3)'(s2_hue) * (F+3)'(6);
  assign pr_f = (2*F+2)'(s3_sat) * (2*F+2)'(s3_f) + (2*F+2)'(One >> 1);
  assign pr_g = (2*F+2)'(s3_sat) * (2*F+2)'(One - (F+1)'(s3_f)) + (2*F+2)'(One >> 1);
  assign pr_p = (2*F+2)'(s4_val) * (2*F+2)'(One - s4_sat) + (2*F+2)'(One >> 1);
  assign pr_q = (2*F+2)'(s4_val) * (2*F+2)'(One - s4_sf) + (2*F+2)'(One >> 1);
  assign pr_t = (2*F+2)'(s4_val) * (2*F+2)'(One - s4_sg) + (2*F+2)'(One >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NS-2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dr_s[0] <= st_s[0][10:0];
      dr_h[0] <= st_h[0][10:0];
      dq_s[0] <= {(F+1)'(0), st_s[0][11]};
      dq_h[0] <= {(F+1)'(0), st_h[0][11]};
      dd_s[0] <= word_i.mx;
      dd_h[0] <= hden;
      dv[0]   <= by255(word_i.mx);
      da[0]   <= by255(word_i.alpha);
      dnz     <= {dnz[DS-2:0], word_i.delta != '0};
      for (int k = 1; k < DS; k++) begin
        dr_s[k] <= st_s[k][10:0];
        dr_h[k] <= st_h[k][10:0];
        dq_s[k] <= {dq_s[k-1][F:0], st_s[k][11]};
        dq_h[k] <= {dq_h[k-1][F:0], st_h[k][11]};
        dd_s[k] <= dd_s[k-1];
        dd_h[k] <= dd_h[k-1];
        dv[k]   <= dv[k-1];
        da[k]   <= da[k-1];
      end

      s2_hue <= s1_hue + hsh;
      s2_sat <= clamp($signed({3'b0, s1_sat}) + scl(sat_shift_i));
      s2_val <= clamp($signed({3'b0, s1_val}) + scl(val_shift_i));
      s2_alp <= clamp($signed({3'b0, s1_alp}) + scl(alpha_shift_i));

      s3_sec <= h6[F+2:F];
      s3_f   <= h6[F-1:0];
      s3_sat <= s2_sat;
      s3_val <= s2_val;
      s3_alp <= s2_alp;

      s4_sf  <= pr_f[2*F:F];
      s4_sg  <= pr_g[2*F:F];
      s4_sec <= s3_sec;
      s4_sat <= s3_sat;
      s4_val <= s3_val;
      s4_alp <= s3_alp;

      s5_p   <= pr_p[2*F:F];
      s5_q   <= pr_q[2*F:F];
      s5_t   <= pr_t[2*F:F];
      s5_sec <= s4_sec;
      s5_val <= s4_val;
      s5_alp <= s4_alp;

      case (s5_sec)
        3'd0: begin s6_r <= s5_val; s6_g <= s5_t; s6_b <= s5_p; end
        3'd1: begin s6_r <= s5_q; s6_g <= s5_val; s6_b <= s5_p; end
        3'd2: begin s6_r <= s5_p; s6_g <= s5_val; s6_b <= s5_t; end
        3'd3: begin s6_r <= s5_p; s6_g <= s5_q; s6_b <= s5_val; end
        3'd4: begin s6_r <= s5_t; s6_g <= s5_p; s6_b <= s5_val; end
        default: begin s6_r <= s5_val; s6_g <= s5_p; s6_b <= s5_q; end
      endcase
      s6_a <= s5_alp;

      s7_d <= {to_byte(s6_a), to_byte(s6_b), to_byte(s6_g), to_byte(s6_r)};
      s8_d <= s7_d;
    end
  end

  assign valid_o = v_q[NS-1];
  assign data_o  = s8_d;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(data_o)) else $error("result lost on stall");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> v_q[0]) else $error("accepted word not tracked");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> ready_o) else $error("back stalls while empty");
`endif

endmodule

@@ rtl/hsv_offset_color_adjust.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsv_offset_color_adjust
// rgba pixel hue/saturation/value/alpha offset adjust through hsv space
// ---------------------------------------------------------------------------
// pipeline: front register, queue slot, FracBits+2 divider stages and seven
//   arithmetic stages (offsets, sector, s*f products, p q t, channel pick, bytes)
// throughput: one pixel per clock unless the output stalls; the divider retires one
// quotient bit per stage; the queue absorbs stalls so front and back stall on their own
// reset: asynchronous, active low; clears valids, queue and all offsets to zero
module hsv_offset_color_adjust #(
  parameter int unsigned FracBits = hsv_adj_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);

  logic [15:0] hue_q;
  logic signed [17:0] sat_q, val_q, alp_q;
  logic fv, fr, qv, qr;
  hsv_adj_pkg::front_word_t fw, qw;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= '0;
      sat_q <= '0;
      val_q <= '0;
      alp_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (hsv_adj_pkg::cfg_idx_e'(cfg_index_i))
        hsv_adj_pkg::CFG_HUE:   hue_q <= cfg_data_i[15:0];
        hsv_adj_pkg::CFG_SAT:   sat_q <= cfg_data_i;
        hsv_adj_pkg::CFG_VAL:   val_q <= cfg_data_i;
        hsv_adj_pkg::CFG_ALPHA: alp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hsv_adj_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .red_i(s_axis_tdata[7:0]), .green_i(s_axis_tdata[15:8]),
    .blue_i(s_axis_tdata[23:16]), .alpha_i(s_axis_tdata[31:24]),
    .valid_o(fv), .ready_i(fr), .word_o(fw)
  );

  hsv_adj_queue u_queue (
    .clk_i, .rst_ni,
    .valid_i(fv), .ready_o(fr), .word_i(fw),
    .valid_o(qv), .ready_i(qr), .word_o(qw)
  );

  hsv_adj_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni,
    .valid_i(qv), .ready_o(qr), .word_i(qw),
    .hue_shift_i(hue_q), .sat_shift_i(sat_q), .val_shift_i(val_q), .alpha_shift_i(alp_q),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .data_o(m_axis_tdata)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the hsv offset colour adjust block. A predictor
// in the bench works out each output pixel. The bench drives directed and
// random pixels under several offset settings, with random gaps on the
// input and random stalls on the output.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned Fb = 16;
  localparam longint unsigned One = 64'd1 << Fb;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [17:0] cfg_data_i = '0;

  logic [15:0] hue_off;
  logic [17:0] sat_off, val_off, alpha_off;
  logic [31:0] pixels_expected[$];
  int          errors = 0;
  int          pixels_sent = 0;
  int          pixels_checked = 0;
  int          settings_used = 0;
  int          cycles = 0;
  bit          out_stall_on = 1'b1;

  hsv_offset_color_adjust dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("hsv_offset_color_adjust verification failed");
      $finish;
    end
  end

  function automatic longint unsigned div_rnd(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic longint unsigned mul_q(longint unsigned a, longint unsigned b);
    return (a * b + (One >> 1)) >> Fb;
  endfunction

  function automatic longint unsigned clamp_q(longint x);
    if (x < 0) return 0;
    if (x > longint'(One)) return One;
    return x;
  endfunction

  function automatic logic [7:0] q_to_byte(longint unsigned x);
    return 8'((x * 255 + (One >> 1)) >> Fb);
  endfunction

  function automatic logic [31:0] adjust_pixel(logic [31:0] px);
    longint r, g, b, mx, mn, dl, n;
    longint unsigned hue, sat, val, alpha, h6, f, p, q, t, ro, go, bo;
    r = px[7:0];
    g = px[15:8];
    b = px[23:16];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    hue = 0;
    sat = 0;
    val = div_rnd(mx * One, 255);
    if (dl > 0) begin
      sat = div_rnd(dl * One, mx);
      if (mx == r) n = g - b;
      else if (mx == g) n = (b - r) + 2 * dl;
      else n = (r - g) + 4 * dl;
      if (n < 0) n += 6 * dl;
      hue = div_rnd(n * One, 6 * dl) & (One - 1);
    end
    hue = (hue + hue_off) & (One - 1);
    sat = clamp_q(longint'(sat) + longint'($signed(sat_off)));
    val = clamp_q(longint'(val) + longint'($signed(val_off)));
    alpha = clamp_q(longint'(div_rnd(px[31:24] * One, 255)) +
                    longint'($signed(alpha_off)));
    h6 = hue * 6;
    f = h6 & (One - 1);
    p = mul_q(val, One - sat);
    q = mul_q(val, One - mul_q(sat, f));
    t = mul_q(val, One - mul_q(sat, One - f));
    case (h6 >> Fb)
      0: begin ro = val; go = t; bo = p; end
      1: begin ro = q; go = val; bo = p; end
      2: begin ro = p; go = val; bo = t; end
      3: begin ro = p; go = q; bo = val; end
      4: begin ro = t; go = p; bo = val; end
      default: begin ro = val; go = p; bo = q; end
    endcase
    return {q_to_byte(alpha), q_to_byte(bo), q_to_byte(go), q_to_byte(ro)};
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %08h expected %08h", what, got, want);
  endtask

  // output side: random stalls and comparison against the oldest expectation
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_expected.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, '0);
        end else begin
          want = pixels_expected.pop_front();
          pixels_checked++;
          if (m_axis_tdata[7:0] !== want[7:0]) report_mismatch("red", m_axis_tdata, want);
          if (m_axis_tdata[15:8] !== want[15:8]) report_mismatch("green", m_axis_tdata, want);
          if (m_axis_tdata[23:16] !== want[23:16]) report_mismatch("blue", m_axis_tdata, want);
          if (m_axis_tdata[31:24] !== want[31:24]) report_mismatch("alpha", m_axis_tdata, want);
        end
      end
      m_axis_tready <= !out_stall_on || ($urandom_range(0, 99) < 70);
    end
  end

  // valid stays high into the next word when there is no gap
  task automatic send_pixel(logic [31:0] px);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_expected.push_back(adjust_pixel(px));
    pixels_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pixels_expected.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(hsv_adj_pkg::cfg_idx_e idx, logic [17:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      hsv_adj_pkg::CFG_HUE: hue_off = data[15:0];
      hsv_adj_pkg::CFG_SAT: sat_off = data;
      hsv_adj_pkg::CFG_VAL: val_off = data;
      default: alpha_off = data;
    endcase
  endtask

  task automatic apply_offsets(logic [15:0] h, int s, int v, int a);
    wait_drained();
    write_reg(hsv_adj_pkg::CFG_HUE, {2'b00, h});
    write_reg(hsv_adj_pkg::CFG_SAT, 18'(s));
    write_reg(hsv_adj_pkg::CFG_VAL, 18'(v));
    write_reg(hsv_adj_pkg::CFG_ALPHA, 18'(a));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] px;
    px = $urandom;
    // bias a share toward gray and saturated corners
    case ($urandom_range(0, 9))
      0: px[23:8] = {px[7:0], px[7:0]};
      1: px[15:8] = px[7:0];
      2: px[7:0] = 8'hff;
      default: ;
    endcase
    return px;
  endfunction

  task automatic test_directed();
    logic [31:0] pix[$] = '{32'h00000000, 32'hffffffff, 32'h80808080, 32'hff0000ff,
                            32'h0000ff00, 32'h00ff0000, 32'h7f00ffff, 32'h01ff00ff,
                            32'h00ffff00, 32'hffff00ff, 32'h10203040, 32'hff0101fe,
                            32'h00fe0001, 32'h80ff7f01, 32'h550000ff, 32'hc0ff80ff};
    foreach (pix[i]) send_pixel(pix[i]);
  endtask

  task automatic test_offset_extremes();
    apply_offsets(16'hffff, 65536, 65536, 65536);
    test_directed();
    apply_offsets(16'h8000, -65536, -65536, -65536);
    test_directed();
    apply_offsets(16'h0001, 18'sh1ffff, -131072, 18'sh1ffff);
    test_directed();
  endtask

  task automatic test_random(int count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 8; k++) begin
      apply_offsets(16'($urandom), $signed(18'($urandom)), $signed(18'($urandom)),
                    $signed(18'($urandom)));
      test_random(100);
    end
    apply_offsets(16'h2aaa, 20000, -20000, 0);
    test_random(80);
    // hold off until the pipe is empty, then run with no output stalls
    wait_drained();
    out_stall_on = 1'b0;
    test_random(100);
    out_stall_on = 1'b1;
  endtask

  initial begin
    hue_off = '0;
    sat_off = '0;
    val_off = '0;
    alpha_off = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_offset_extremes();
    apply_offsets(16'h0000, 0, 0, 0);
    test_random(100);
    test_random_settings();
    wait_drained();
    $display("sent %0d pixels, checked %0d, over %0d offset settings",
             pixels_sent, pixels_checked, settings_used);
    $display("directed corners, offset extremes and random pixels with gaps and stalls");
    if (errors == 0) begin
      $display("hsv_offset_color_adjust verification clean");
    end else begin
      $display("hsv_offset_color_adjust verification failed");
    end
    $finish;
  end
endmodule

@@ hsv_offset_color_adjust.f @@
rtl/hsv_adj_pkg.sv
rtl/hsv_adj_front.sv
rtl/hsv_adj_queue.sv
rtl/hsv_adj_back.sv
rtl/hsv_offset_color_adjust.sv
tb/tb.sv
